// ----- hdl/sntd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntd_pkg : shared types and constants of the note timing decoder
// Command codes passed from the decoder front end to the note engine, result
// kinds, opcode values and the note length table.
// ----------------------------------------------------------------------------
package sntd_pkg;

   // Opcodes below the note range, the note base opcode and the LFO restart type
   localparam logic [7:0] OP_TRIPLET   = 8'h00;
   localparam logic [7:0] OP_SLUR      = 8'h01;
   localparam logic [7:0] OP_DOT       = 8'h02;
   localparam logic [7:0] OP_OCTAVE_UP = 8'h03;
   localparam logic [7:0] OP_ATTR      = 8'h04;
   localparam logic [7:0] OP_RATE      = 8'h06;
   localparam logic [7:0] OP_OCTAVE    = 8'h09;
   localparam logic [7:0] OP_TRANSPOSE = 8'h0b;
   localparam logic [7:0] OP_PORTA     = 8'h0d;
   localparam logic [7:0] OP_FLOW_LO   = 8'h0e;
   localparam logic [7:0] OP_FLOW_HI   = 8'h16;
   localparam logic [7:0] OP_END       = 8'h17;
   localparam logic [7:0] OP_LFO       = 8'h1a;
   localparam logic [7:0] OP_NOTE_BASE = 8'h20;
   localparam logic [7:0] LFO_TYPE_RESTART = 8'h03;

   // Attribute byte bits
   localparam int unsigned ATTR_OCT_UP  = 3;
   localparam int unsigned ATTR_DOT     = 4;
   localparam int unsigned ATTR_TRIPLET = 5;
   localparam int unsigned ATTR_SLUR    = 6;

   // Result kinds
   localparam logic [2:0] KIND_STATE   = 3'd0;
   localparam logic [2:0] KIND_NOTE    = 3'd1;
   localparam logic [2:0] KIND_REST    = 3'd2;
   localparam logic [2:0] KIND_END     = 3'd3;
   localparam logic [2:0] KIND_UNSUPP  = 3'd4;
   localparam logic [2:0] KIND_FLOW    = 3'd5;

   // Command codes from the front end
   localparam logic [3:0] CMD_NOP       = 4'd0;
   localparam logic [3:0] CMD_START     = 4'd1;
   localparam logic [3:0] CMD_NOTE      = 4'd2;
   localparam logic [3:0] CMD_TRIPLET   = 4'd3;
   localparam logic [3:0] CMD_SLUR      = 4'd4;
   localparam logic [3:0] CMD_DOT       = 4'd5;
   localparam logic [3:0] CMD_OCT_UP    = 4'd6;
   localparam logic [3:0] CMD_ATTR      = 4'd7;
   localparam logic [3:0] CMD_RATE      = 4'd8;
   localparam logic [3:0] CMD_OCTAVE    = 4'd9;
   localparam logic [3:0] CMD_TRANSPOSE = 4'd10;
   localparam logic [3:0] CMD_PORTA     = 4'd11;
   localparam logic [3:0] CMD_FLOW      = 4'd12;
   localparam logic [3:0] CMD_END       = 4'd13;
   localparam logic [3:0] CMD_LFO       = 4'd14;

   localparam int unsigned KEY_W   = 13;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W  = 1;
   localparam int unsigned QCNT_W  = 2;

   typedef struct packed {
      logic [3:0] cmd;
      logic [2:0] dur_idx;
      logic [4:0] key_idx;
      logic [7:0] arg;
   } sntd_cmd_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [KEY_W-1:0] note_key;
      logic [7:0]              sounding_ticks;
      logic [7:0]              wait_ticks;
      logic                    extends_previous;
      logic                    restarts_lfo;
      logic                    pedal_event;
      logic                    pedal_on;
      logic                    slide_valid;
      logic signed [KEY_W-1:0] slide_start_key;
   } sntd_rsp_type;

   // Note length in ticks: 192 >> (7 - index) for index 1 to 7 and zero for index 0, then dotted or triplet
   function automatic logic [7:0] note_length(input logic [2:0] idx,
                                              input logic dotted,
                                              input logic triplet);
      logic [7:0] base;
      logic [7:0] res;
      case (idx)
         3'd0: base = 8'd0;
         3'd1: base = 8'd3;
         3'd2: base = 8'd6;
         3'd3: base = 8'd12;
         3'd4: base = 8'd24;
         3'd5: base = 8'd48;
         3'd6: base = 8'd96;
         3'd7: base = 8'd192;
         default: base = 8'd0;
      endcase
      if (dotted) begin
         if (!base[0] && (base < 8'h80)) begin
            res = base + (base >> 1);
         end else begin
            res = 8'd0;
         end
      end else if (triplet) begin
         // two thirds of each table length
         case (idx)
            3'd1: res = 8'd2;
            3'd2: res = 8'd4;
            3'd3: res = 8'd8;
            3'd4: res = 8'd16;
            3'd5: res = 8'd32;
            3'd6: res = 8'd64;
            3'd7: res = 8'd128;
            default: res = 8'd0;
         endcase
      end else begin
         res = base;
      end
      return res;
   endfunction

endpackage

// ----- hdl/sequence_note_timing_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_note_timing_decoder : track note and timing decoder
// One result word per track word: a classifier front end, a two-word command
// queue and a note engine with a registered result output.
// ----------------------------------------------------------------------------
// Takes one track word per clock while the rsp side keeps up and returns
// exactly one result word for it, in order. An accepted word is stored in the
// command queue, then the note engine registers its result on the rsp side.
// The engine's step (length table, one 8x8 multiply and the key adders) keeps
// the rate at one word per cycle. The queue holds two words, so
// the request side takes two more words while a result waits on a stalled rsp
// side and only then holds off. The csr write is always accepted; write it
// only while no word is in flight. It takes effect at the next track start
// word.
module sequence_note_timing_decoder (
   input  logic        clock,
   input  logic        reset,
   // configuration: bit 0 selects the first driver version
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[7:0], arg_a[15:8], arg_b[23:16]
   input  logic        req_tuser,   // func
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // note_key[12:0], sounding_ticks[20:13],
                                    // wait_ticks[28:21], extends_previous[29],
                                    // restarts_lfo[30], pedal_event[31],
                                    // pedal_on[32], slide_valid[33],
                                    // slide_start_key[46:34], zero[47]
   output logic [2:0]  rsp_tuser    // kind
);
   import sntd_pkg::*;

   sntd_cmd_type front_cmd;
   sntd_cmd_type queue_cmd;
   sntd_rsp_type rsp;
   logic         queue_valid;
   logic         queue_ready;

   assign csr_ready = 1'b1;

   sntd_front u_front (
      .func   (req_tuser),
      .opcode (req_tdata[7:0]),
      .arg_a  (req_tdata[15:8]),
      .arg_b  (req_tdata[23:16]),
      .cmd    (front_cmd)
   );

   sntd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   sntd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_value (csr_data),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result word
   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {1'b0,
                       rsp.slide_start_key,
                       rsp.slide_valid,
                       rsp.pedal_on,
                       rsp.pedal_event,
                       rsp.restarts_lfo,
                       rsp.extends_previous,
                       rsp.wait_ticks,
                       rsp.sounding_ticks,
                       rsp.note_key};

endmodule

// ----- hdl/sntd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntd_front : command classifier
// Turns a raw track word (selector, opcode, operands) into a compact command
// for the note engine. Pure decode; the queue behind it holds the result.
// ----------------------------------------------------------------------------
module sntd_front (
   input  logic               func,
   input  logic [7:0]         opcode,
   input  logic [7:0]         arg_a,
   input  logic [7:0]         arg_b,
   output sntd_pkg::sntd_cmd_type cmd
);
   import sntd_pkg::*;

   // Classify the word
   always_comb begin
      cmd.cmd     = CMD_NOP;
      cmd.dur_idx = opcode[7:5];
      cmd.key_idx = opcode[4:0];
      cmd.arg     = arg_a;
      if (func) begin
         cmd.cmd = CMD_START;
      end else if (opcode >= OP_NOTE_BASE) begin
         cmd.cmd = CMD_NOTE;
      end else if ((opcode >= OP_FLOW_LO) && (opcode <= OP_FLOW_HI)) begin
         cmd.cmd = CMD_FLOW;
      end else begin
         case (opcode)
            OP_TRIPLET:   cmd.cmd = CMD_TRIPLET;
            OP_SLUR:      cmd.cmd = CMD_SLUR;
            OP_DOT:       cmd.cmd = CMD_DOT;
            OP_OCTAVE_UP: cmd.cmd = CMD_OCT_UP;
            OP_ATTR:      cmd.cmd = CMD_ATTR;
            OP_RATE:      cmd.cmd = CMD_RATE;
            OP_OCTAVE:    cmd.cmd = CMD_OCTAVE;
            OP_TRANSPOSE: cmd.cmd = CMD_TRANSPOSE;
            OP_PORTA:     cmd.cmd = CMD_PORTA;
            OP_END:       cmd.cmd = CMD_END;
            OP_LFO: begin
               // only the restart type matters; carry the value byte
               if (arg_a == LFO_TYPE_RESTART) begin
                  cmd.cmd = CMD_LFO;
               end
               cmd.arg = arg_b;
            end
            default: cmd.cmd = CMD_NOP;
         endcase
      end
   end

endmodule

// ----- hdl/sntd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntd_queue : command queue
// Two-word queue between the classifier and the note engine; a stalled engine
// holds off the classifier side only once the queue is full.
// ----------------------------------------------------------------------------
module sntd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  sntd_pkg::sntd_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output sntd_pkg::sntd_cmd_type pop_cmd
);
   import sntd_pkg::*;

   sntd_cmd_type       store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// ----- hdl/sntd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntd_back : note engine
// Holds the per-track note state, carries out one queued command per cycle while
// results are taken and keeps each result word in an output register until taken.
// ----------------------------------------------------------------------------
module sntd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_value,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  sntd_pkg::sntd_cmd_type cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sntd_pkg::sntd_rsp_type rsp
);
   import sntd_pkg::*;

   logic                     first_version_ff, first_version_in;
   logic [7:0]               rate_ff,      rate_in;
   logic signed [7:0]        transpose_ff, transpose_in;
   logic [7:0]               octave_ff,    octave_in;
   logic                     oct_up_ff,    oct_up_in;
   logic                     dotted_ff,    dotted_in;
   logic                     triplet_ff,   triplet_in;
   logic                     slur_ff,      slur_in;
   logic                     lfo_en_ff,    lfo_en_in;
   logic                     porta_ff,     porta_in;
   logic                     have_last_ff, have_last_in;
   logic signed [KEY_W-1:0]  last_key_ff,  last_key_in;
   logic                     last_slur_ff, last_slur_in;
   logic                     rested_ff,    rested_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sntd_rsp_type             rsp_ff,       rsp_in;

   logic                     pop;
   logic [7:0]               len;
   logic [8:0]               oct_sum;
   logic [KEY_W-1:0]         oct_mul;
   logic signed [KEY_W-1:0]  key;
   logic signed [KEY_W-1:0]  transpose_ext;
   logic [15:0]              prod;
   logic [16:0]              prod_round;
   logic [7:0]               snd_base;
   logic [7:0]               snd;
   logic                     cont;
   logic                     rep;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Note arithmetic: length, key, sounding ticks
   always_comb begin
      len           = note_length(cmd.dur_idx, dotted_ff, triplet_ff);
      oct_sum       = {1'b0, octave_ff} + (oct_up_ff ? 9'd2 : 9'd0);
      oct_mul       = ({4'd0, oct_sum} << 3) + ({4'd0, oct_sum} << 2);
      key           = $signed(oct_mul + {8'd0, cmd.key_idx} - KEY_W'(1));
      transpose_ext = KEY_W'(transpose_ff);
      prod          = len * rate_ff;
      prod_round    = {1'b0, prod} + 17'h80;
      if (slur_ff || (prod == 16'd0)) begin
         snd_base = len;
      end else begin
         snd_base = prod_round[15:8];
      end
      cont = last_slur_ff && !rested_ff && have_last_ff;
      rep  = cont && (key == last_key_ff);
      snd  = (snd_base == 8'd0) ? 8'd1 : snd_base;
      if (slur_ff && !rep) begin
         snd = snd + 8'd1;
      end
   end

   // Carry out the command
   always_comb begin
      first_version_in = csr_write ? csr_value : first_version_ff;
      rate_in      = rate_ff;
      transpose_in = transpose_ff;
      octave_in    = octave_ff;
      oct_up_in    = oct_up_ff;
      dotted_in    = dotted_ff;
      triplet_in   = triplet_ff;
      slur_in      = slur_ff;
      lfo_en_in    = lfo_en_ff;
      porta_in     = porta_ff;
      have_last_in = have_last_ff;
      last_key_in  = last_key_ff;
      last_slur_in = last_slur_ff;
      rested_in    = rested_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.kind  = KIND_STATE;
         case (cmd.cmd)
            CMD_START: begin
               rate_in      = '0;
               transpose_in = '0;
               octave_in    = '0;
               oct_up_in    = 1'b0;
               dotted_in    = 1'b0;
               triplet_in   = 1'b0;
               slur_in      = 1'b0;
               lfo_en_in    = !first_version_ff;
               porta_in     = 1'b0;
               have_last_in = 1'b0;
               last_key_in  = '0;
               last_slur_in = 1'b0;
               rested_in    = 1'b0;
            end
            CMD_NOTE: begin
               dotted_in = 1'b0;
               rsp_in.wait_ticks = len;
               if (cmd.key_idx == 5'd0) begin
                  rested_in   = 1'b1;
                  rsp_in.kind = KIND_REST;
               end else begin
                  rsp_in.kind             = KIND_NOTE;
                  rsp_in.note_key         = key + transpose_ext;
                  rsp_in.sounding_ticks   = snd;
                  rsp_in.extends_previous = rep;
                  rsp_in.restarts_lfo     = lfo_en_ff && !last_slur_ff;
                  if (!rep && have_last_ff && (porta_ff || cont) && (last_key_ff != key)) begin
                     rsp_in.slide_valid     = 1'b1;
                     rsp_in.slide_start_key = last_key_ff + transpose_ext;
                  end
                  last_key_in  = key;
                  have_last_in = 1'b1;
                  rested_in    = 1'b0;
                  last_slur_in = slur_ff;
               end
            end
            CMD_TRIPLET: triplet_in = !triplet_ff;
            CMD_SLUR: begin
               slur_in            = !slur_ff;
               rsp_in.pedal_event = 1'b1;
               rsp_in.pedal_on    = !slur_ff;
            end
            CMD_DOT:    dotted_in = 1'b1;
            CMD_OCT_UP: oct_up_in = !oct_up_ff;
            CMD_ATTR: begin
               octave_in  = octave_ff | {5'd0, cmd.arg[2:0]};
               dotted_in  = dotted_ff | cmd.arg[ATTR_DOT];
               oct_up_in  = cmd.arg[ATTR_OCT_UP];
               triplet_in = cmd.arg[ATTR_TRIPLET];
               slur_in    = cmd.arg[ATTR_SLUR];
               if (cmd.arg[ATTR_SLUR] != slur_ff) begin
                  rsp_in.pedal_event = 1'b1;
                  rsp_in.pedal_on    = cmd.arg[ATTR_SLUR];
               end
            end
            CMD_RATE:      rate_in      = cmd.arg;
            CMD_OCTAVE:    octave_in    = cmd.arg;
            CMD_TRANSPOSE: transpose_in = $signed(cmd.arg);
            CMD_PORTA:     porta_in     = (cmd.arg[6:0] != 7'd0);
            CMD_FLOW:      rsp_in.kind  = KIND_FLOW;
            CMD_END:       rsp_in.kind  = KIND_END;
            CMD_LFO:       lfo_en_in    = cmd.arg[0];
            default: ;
         endcase
      end
   end

   // Hold control and note state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_version_ff <= 1'b0;
         rate_ff      <= '0;
         transpose_ff <= '0;
         octave_ff    <= '0;
         oct_up_ff    <= 1'b0;
         dotted_ff    <= 1'b0;
         triplet_ff   <= 1'b0;
         slur_ff      <= 1'b0;
         lfo_en_ff    <= 1'b1;
         porta_ff     <= 1'b0;
         have_last_ff <= 1'b0;
         last_key_ff  <= '0;
         last_slur_ff <= 1'b0;
         rested_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_version_ff <= first_version_in;
         rate_ff      <= rate_in;
         transpose_ff <= transpose_in;
         octave_ff    <= octave_in;
         oct_up_ff    <= oct_up_in;
         dotted_ff    <= dotted_in;
         triplet_ff   <= triplet_in;
         slur_ff      <= slur_in;
         lfo_en_ff    <= lfo_en_in;
         porta_ff     <= porta_in;
         have_last_ff <= have_last_in;
         last_key_ff  <= last_key_in;
         last_slur_ff <= last_slur_in;
         rested_ff    <= rested_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result word overwritten");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && (cmd.cmd == CMD_START)) |=> (!have_last_ff && !slur_ff && !dotted_ff))
      else $error("track start left note state behind");

   a_note_marks: assert property (@(posedge clock) disable iff (reset)
      (pop && (cmd.cmd == CMD_NOTE) && (cmd.key_idx != 5'd0))
         |=> (have_last_ff && !rested_ff && (rsp_ff.kind == KIND_NOTE)))
      else $error("note did not record its key");

   a_no_unsupp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.kind != KIND_UNSUPP))
      else $error("unsupported kind produced");

endmodule

// ----- bench/tb_sequence_note_timing_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_note_timing_decoder : self-checking bench of the note decoder
// Drives track words with bursty timing and takes results against a stalling
// receiver. Expected results come from a behavioural copy of the per-track note
// state kept in this file. A short directed table covers the extremes and every
// command. Random phases follow under both driver-version settings.
// ----------------------------------------------------------------------------
module tb_sequence_note_timing_decoder;
   import sntd_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned HOLD_AFTER   = 120;
   localparam int unsigned PHASE_WORDS  = 160;
   localparam int unsigned REPORT_MAX   = 10;
   localparam logic [7:0]  OP_SPARE_1F  = 8'h1f;

   typedef struct packed {
      logic       func;
      logic [7:0] opcode;
      logic [7:0] arg_a;
      logic [7:0] arg_b;
   } track_word_type;

   // one directed row; given marks an expectation typed in by hand
   typedef struct packed {
      track_word_type w;
      logic           given;
      logic [2:0]     kind;
      logic           pedal_event;
      logic           pedal_on;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   // per-track note state of the behavioural copy
   logic       cfg_first_version = 1'b0;
   logic [7:0] trk_rate;
   int         trk_transpose;
   logic [7:0] trk_octave;
   logic       trk_oct_up, trk_dotted, trk_triplet, trk_slur;
   logic       trk_lfo_restart, trk_porta, trk_have_note, trk_last_slur, trk_rested;
   int         trk_last_key;

   sntd_rsp_type pending_results[$];
   stim_row_type dir_table[$];
   logic [7:0]   last_note_op = 8'h00;

   int unsigned words_sent = 0, results_checked = 0, mismatches = 0, unexpected = 0;
   int unsigned notes_seen = 0, rests_seen = 0, glides_seen = 0, repeats_seen = 0;
   int unsigned input_stalls = 0, idle_cycles = 0;

   sequence_note_timing_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Return the note state to its track-start values
   function automatic void clear_note_state();
      trk_rate        = '0;
      trk_transpose   = 0;
      trk_octave      = '0;
      trk_oct_up      = 1'b0;
      trk_dotted      = 1'b0;
      trk_triplet     = 1'b0;
      trk_slur        = 1'b0;
      trk_lfo_restart = !cfg_first_version;
      trk_porta       = 1'b0;
      trk_have_note   = 1'b0;
      trk_last_key    = 0;
      trk_last_slur   = 1'b0;
      trk_rested      = 1'b0;
   endfunction

   // Work out the result of one track word and advance the note state
   function automatic sntd_rsp_type decode_track_word(input track_word_type w);
      sntd_rsp_type r;
      int unsigned  len, prod, snd;
      int           octave, key;
      logic         cont, rep, was;
      r = '0;
      if (w.func) begin
         clear_note_state();
         return r;
      end
      if (w.opcode >= OP_NOTE_BASE) begin
         // length from the duration index, then dotted or triplet
         len = 32'd192 >> (7 - int'(w.opcode[7:5]));
         if (trk_dotted) begin
            len = (len % 2 == 0 && len < 8'h80) ? len + len / 2 : 0;
            trk_dotted = 1'b0;
         end else if (trk_triplet) begin
            len = len * 2 / 3;
         end
         if (w.opcode[4:0] == 5'd0) begin
            trk_rested   = 1'b1;
            r.kind       = KIND_REST;
            r.wait_ticks = len[7:0];
            return r;
         end
         octave = int'(trk_octave) + (trk_oct_up ? 2 : 0);
         key    = int'(w.opcode[4:0]) - 1 + octave * 12;
         prod   = len * trk_rate;
         if (trk_slur || prod == 0) prod = len << 8;
         snd = (prod + 32'h80) >> 8;
         if (snd == 0) snd = 1;
         cont = trk_last_slur && !trk_rested && trk_have_note;
         rep  = cont && (key == trk_last_key);
         if (trk_slur && !rep) snd = snd + 1;
         r.kind             = KIND_NOTE;
         r.note_key         = 13'(key + trk_transpose);
         r.sounding_ticks   = snd[7:0];
         r.wait_ticks       = len[7:0];
         r.extends_previous = rep;
         r.restarts_lfo     = trk_lfo_restart && !trk_last_slur;
         if (!rep && trk_have_note && (trk_porta || cont) && trk_last_key != key) begin
            r.slide_valid     = 1'b1;
            r.slide_start_key = 13'(trk_last_key + trk_transpose);
         end
         trk_last_key  = key;
         trk_have_note = 1'b1;
         trk_rested    = 1'b0;
         trk_last_slur = trk_slur;
      end else if (w.opcode >= OP_FLOW_LO && w.opcode <= OP_FLOW_HI) begin
         r.kind = KIND_FLOW;
      end else begin
         case (w.opcode)
            OP_TRIPLET:   trk_triplet = !trk_triplet;
            OP_SLUR: begin
               trk_slur      = !trk_slur;
               r.pedal_event = 1'b1;
               r.pedal_on    = trk_slur;
            end
            OP_DOT:       trk_dotted = 1'b1;
            OP_OCTAVE_UP: trk_oct_up = !trk_oct_up;
            OP_ATTR: begin
               // octave bits are ORed in, the dot bit only ever sets
               was        = trk_slur;
               trk_octave = trk_octave | {5'd0, w.arg_a[ATTR_OCT_UP-1:0]};
               if (w.arg_a[ATTR_DOT]) trk_dotted = 1'b1;
               trk_oct_up  = w.arg_a[ATTR_OCT_UP];
               trk_triplet = w.arg_a[ATTR_TRIPLET];
               trk_slur    = w.arg_a[ATTR_SLUR];
               if (trk_slur != was) begin
                  r.pedal_event = 1'b1;
                  r.pedal_on    = trk_slur;
               end
            end
            OP_RATE:      trk_rate = w.arg_a;
            OP_OCTAVE:    trk_octave = w.arg_a;
            OP_TRANSPOSE: trk_transpose = int'($signed(w.arg_a));
            OP_PORTA:     trk_porta = (w.arg_a[6:0] != 7'd0);
            OP_END:       r.kind = KIND_END;
            OP_LFO: begin
               if (w.arg_a == LFO_TYPE_RESTART) trk_lfo_restart = w.arg_b[0];
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] note_op(input int unsigned dur, input int unsigned key_idx);
      return {3'(dur), 5'(key_idx)};
   endfunction

   function automatic stim_row_type stim(input logic func, input logic [7:0] op,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic given, input logic [2:0] kind,
                                         input logic pev, input logic pon);
      stim_row_type s;
      s.w           = '{func: func, opcode: op, arg_a: a, arg_b: b};
      s.given       = given;
      s.kind        = kind;
      s.pedal_event = pev;
      s.pedal_on    = pon;
      return s;
   endfunction

   // Random track word: mostly notes and note-state commands with random operands
   function automatic track_word_type random_word();
      track_word_type w;
      int unsigned    pick;
      logic [7:0]     state_ops[10];
      state_ops = '{OP_TRIPLET, OP_SLUR, OP_DOT, OP_OCTAVE_UP, OP_ATTR,
                    OP_RATE, OP_OCTAVE, OP_TRANSPOSE, OP_PORTA, OP_LFO};
      w.func  = 1'b0;
      w.arg_a = 8'($urandom);
      w.arg_b = 8'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 2) begin
         w.func   = 1'b1;
         w.opcode = 8'($urandom);
      end else if (pick < 42) begin
         // a quarter of the notes reuse the previous key index
         if ($urandom_range(0, 3) == 0 && last_note_op != 8'h00)
            w.opcode = note_op($urandom_range(1, 7), last_note_op[4:0]);
         else
            w.opcode = note_op($urandom_range(1, 7), $urandom_range(1, 31));
         last_note_op = w.opcode;
      end else if (pick < 50) begin
         w.opcode = note_op($urandom_range(1, 7), 0);
      end else if (pick < 85) begin
         w.opcode = state_ops[$urandom_range(0, 9)];
         if (w.opcode == OP_OCTAVE && $urandom_range(0, 7) != 0)
            w.arg_a = 8'($urandom_range(0, 5));
         if (w.opcode == OP_LFO && $urandom_range(0, 1) == 0)
            w.arg_a = LFO_TYPE_RESTART;
      end else if (pick < 92) begin
         w.opcode = 8'($urandom_range(OP_FLOW_LO, OP_END));
      end else begin
         w.opcode = 8'($urandom);
      end
      return w;
   endfunction

   function automatic logic [9:0] field_diff(input sntd_rsp_type e, input sntd_rsp_type g);
      return {e.slide_start_key != g.slide_start_key, e.slide_valid != g.slide_valid,
              e.pedal_on != g.pedal_on, e.pedal_event != g.pedal_event,
              e.restarts_lfo != g.restarts_lfo, e.extends_previous != g.extends_previous,
              e.wait_ticks != g.wait_ticks, e.sounding_ticks != g.sounding_ticks,
              e.note_key != g.note_key, e.kind != g.kind};
   endfunction

   // Offer one word, hold it until taken, then log its expected result
   task automatic offer_word(input track_word_type w, input logic given,
                             input sntd_rsp_type fixed);
      sntd_rsp_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {w.arg_b, w.arg_a, w.opcode};
      req_tuser  <= w.func;
      do @(posedge clock); while (!req_tready);
      predicted = decode_track_word(w);
      pending_results.push_back(given ? fixed : predicted);
      words_sent++;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drain, then change the driver version while nothing is in flight
   task automatic write_version(input logic v);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      cfg_first_version = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int unsigned count);
      int unsigned    burst_left;
      track_word_type start_word;
      burst_left = 0;
      start_word = '{func: 1'b1, opcode: 8'h00, arg_a: 8'h00, arg_b: 8'h00};
      offer_word(start_word, 1'b0, '0);
      for (int unsigned n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
         end
         offer_word(random_word(), 1'b0, '0);
         burst_left--;
      end
      idle_sender(1);
   endtask

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin : result_check
      sntd_rsp_type got, want;
      logic [9:0]   diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind             = rsp_tuser;
         got.note_key         = rsp_tdata[12:0];
         got.sounding_ticks   = rsp_tdata[20:13];
         got.wait_ticks       = rsp_tdata[28:21];
         got.extends_previous = rsp_tdata[29];
         got.restarts_lfo     = rsp_tdata[30];
         got.pedal_event      = rsp_tdata[31];
         got.pedal_on         = rsp_tdata[32];
         got.slide_valid      = rsp_tdata[33];
         got.slide_start_key  = rsp_tdata[46:34];
         if (pending_results.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_MAX)
               $display("%0t: result word with nothing expected, kind %0d", $realtime,
                        got.kind);
         end else begin
            want = pending_results.pop_front();
            diff = field_diff(want, got);
            if (diff != '0) begin
               mismatches++;
               if (mismatches + unexpected <= REPORT_MAX) begin
                  $display("%0t: result %0d fields %b differ",
                           $realtime, results_checked, diff);
                  $display("   exp kind %0d key %0d snd %0d wait %0d ext %b lfo %b %s",
                           want.kind, want.note_key, want.sounding_ticks,
                           want.wait_ticks, want.extends_previous, want.restarts_lfo,
                           "");
                  $display("       ped %b/%b slide %b/%0d",
                           want.pedal_event, want.pedal_on, want.slide_valid,
                           want.slide_start_key);
                  $display("   got kind %0d key %0d snd %0d wait %0d ext %b lfo %b %s",
                           got.kind, got.note_key, got.sounding_ticks,
                           got.wait_ticks, got.extends_previous, got.restarts_lfo,
                           "");
                  $display("       ped %b/%b slide %b/%0d",
                           got.pedal_event, got.pedal_on, got.slide_valid,
                           got.slide_start_key);
               end
            end
         end
         results_checked++;
         if (got.kind == KIND_NOTE) notes_seen++;
         if (got.kind == KIND_REST) rests_seen++;
         if (got.slide_valid) glides_seen++;
         if (got.extends_previous) repeats_seen++;
      end
   end

   // Watchdog: end the run after a long stretch with no word moving anywhere
   always @(posedge clock) begin
      if (req_tvalid && !req_tready) input_stalls++;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("tb_sequence_note_timing_decoder: FAIL");
            $finish;
         end
      end
   end

   // Receiver: cycle through pacing patterns, with one long hold-off
   initial begin : rsp_pacing
      int unsigned cyc;
      logic        held;
      cyc  = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (!held && results_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            case ((cyc / 48) % 4)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 2) != 0);
               2:       rsp_tready <= (cyc % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      sntd_rsp_type fixed;
      clear_note_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: extremes, every command and the special cases
      dir_table.push_back(stim(1'b1, 8'h00, 8'h00, 8'h00, 1'b1, KIND_STATE, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(7, 31), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_RATE, 8'hff, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(1, 1), 8'hff, 8'hff, 1'b0, '0, 1'b0, 1'b0));
      // dotted longest note loses its length
      dir_table.push_back(stim(1'b0, OP_DOT, 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(7, 5), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_TRIPLET, 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(2, 0), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      // slur on, same pitch twice, then off
      dir_table.push_back(stim(1'b0, OP_SLUR, 8'h00, 8'h00, 1'b1, KIND_STATE, 1'b1, 1'b1));
      dir_table.push_back(stim(1'b0, note_op(3, 5), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(3, 5), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_SLUR, 8'h00, 8'h00, 1'b1, KIND_STATE, 1'b1, 1'b0));
      // portamento glide from the previous key
      dir_table.push_back(stim(1'b0, OP_PORTA, 8'h01, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(1, 7), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_ATTR, 8'hff, 8'h00, 1'b1, KIND_STATE, 1'b1, 1'b1));
      // highest key: top octave, octave up and largest transpose
      dir_table.push_back(stim(1'b0, OP_OCTAVE, 8'hff, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_TRANSPOSE, 8'h7f, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(1, 31), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      // lowest key: octave zero and most negative transpose
      dir_table.push_back(stim(1'b0, OP_TRANSPOSE, 8'h80, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_OCTAVE, 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_OCTAVE_UP, 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, note_op(4, 1), 8'h00, 8'h00, 1'b0, '0, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_LFO, LFO_TYPE_RESTART, 8'h00, 1'b1, KIND_STATE,
                               1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_FLOW_LO, 8'hff, 8'hff, 1'b1, KIND_FLOW, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_FLOW_HI, 8'h00, 8'h00, 1'b1, KIND_FLOW, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_END, 8'h00, 8'h00, 1'b1, KIND_END, 1'b0, 1'b0));
      dir_table.push_back(stim(1'b0, OP_SPARE_1F, 8'hff, 8'hff, 1'b1, KIND_STATE,
                               1'b0, 1'b0));

      for (int unsigned i = 0; i < dir_table.size(); i++) begin
         row                = dir_table[i];
         fixed              = '0;
         fixed.kind         = row.kind;
         fixed.pedal_event  = row.pedal_event;
         fixed.pedal_on     = row.pedal_on;
         offer_word(row.w, row.given, fixed);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
      end
      idle_sender(1);

      // random phases under alternating driver versions
      write_version(1'b1);
      run_random_phase(PHASE_WORDS);
      write_version(1'b0);
      run_random_phase(PHASE_WORDS);
      write_version(1'b1);
      run_random_phase(PHASE_WORDS);
      write_version(1'b0);
      run_random_phase(PHASE_WORDS);

      // drain, then allow for any stray result words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run covered %0d words over both driver versions, %0d results checked",
               words_sent, results_checked);
      $display("notes %0d, rests %0d, glides %0d, slur repeats %0d, input stalled %0d cycles",
               notes_seen, rests_seen, glides_seen, repeats_seen, input_stalls);
      if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
         $display("tb_sequence_note_timing_decoder: PASS");
      end else begin
         $display("%0d mismatches, %0d unexpected results", mismatches, unexpected);
         $display("tb_sequence_note_timing_decoder: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/sntd_pkg.sv
hdl/sntd_front.sv
hdl/sntd_queue.sv
hdl/sntd_back.sv
hdl/sequence_note_timing_decoder.sv
bench/tb_sequence_note_timing_decoder.sv
